// ===== src/utf8_stream_decoder_assert.svh =====
// Assertion macros shared by the decoder modules
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define UTF8D_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8 decoder: implication check failed");

// Next-cycle implication, checked outside reset
`define UTF8D_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8 decoder: next-cycle check failed");

`endif

// ===== src/utf8d_pkg.sv =====
// Shared types, codes and helpers of the UTF-8 stream decoder
package utf8d_pkg;

    localparam int POS_W = 17;
    localparam int CP_W  = 21;

    // Saturation limit for byte positions and character counts
    localparam logic [POS_W-1:0] MAX_BYTES = 17'd65536;

    // Byte classes produced by the front end
    localparam logic [2:0] CLS_ASCII = 3'd0;
    localparam logic [2:0] CLS_CONT  = 3'd1;
    localparam logic [2:0] CLS_LEAD2 = 3'd2;
    localparam logic [2:0] CLS_LEAD3 = 3'd3;
    localparam logic [2:0] CLS_LEAD4 = 3'd4;
    localparam logic [2:0] CLS_BAD   = 3'd5;

    // Result status codes
    localparam logic [1:0] STATUS_CHAR    = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_DISCARD = 2'd2;

    // Bit masks of the lead and continuation forms
    localparam logic [7:0] TOP1_MASK  = 8'b1000_0000;
    localparam logic [7:0] TOP2_MASK  = 8'b1100_0000;
    localparam logic [7:0] TOP3_MASK  = 8'b1110_0000;
    localparam logic [7:0] TOP4_MASK  = 8'b1111_0000;
    localparam logic [7:0] TOP5_MASK  = 8'b1111_1000;
    localparam logic [7:0] CONT_FORM  = 8'b1000_0000;
    localparam logic [7:0] LEAD2_FORM = 8'b1100_0000;
    localparam logic [7:0] LEAD3_FORM = 8'b1110_0000;
    localparam logic [7:0] LEAD4_FORM = 8'b1111_0000;
    localparam logic [7:0] LEAD2_BITS = 8'b0001_1111;
    localparam logic [7:0] LEAD3_BITS = 8'b0000_1111;
    localparam logic [7:0] LEAD4_BITS = 8'b0000_0111;
    localparam logic [7:0] CONT_BITS  = 8'b0011_1111;

    // One classified byte in the queue between front and back
    typedef struct packed {
        logic [2:0] cls;
        logic [7:0] data;
        logic       last;
    } q_item_t;

    // Increment that holds at the limit
    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        logic [POS_W-1:0] r;
        r = (v >= MAX_BYTES) ? MAX_BYTES : v + 1'b1;
        return r;
    endfunction

endpackage

// ===== src/utf8d_front.sv =====
// Front end: byte classification and a two-entry queue to the back end
`include "utf8_stream_decoder_assert.svh"

module utf8d_front
    import utf8d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       q_valid,
    output q_item_t    q_item,
    input  logic       q_pop
);

    q_item_t    mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic [2:0] cls;

    // Classify the byte by its leading bits
    always_comb
    begin
        if ((data_byte & TOP1_MASK) == 8'h00)
            cls = CLS_ASCII;
        else if ((data_byte & TOP2_MASK) == CONT_FORM)
            cls = CLS_CONT;
        else if ((data_byte & TOP3_MASK) == LEAD2_FORM)
            cls = CLS_LEAD2;
        else if ((data_byte & TOP4_MASK) == LEAD3_FORM)
            cls = CLS_LEAD3;
        else if ((data_byte & TOP5_MASK) == LEAD4_FORM)
            cls = CLS_LEAD4;
        else
            cls = CLS_BAD;
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem[rd_ptr_reg];

    // Queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= '{cls: cls, data: data_byte, last: last_byte};
    end

    `UTF8D_ASSERT_IMP(a_no_pop_empty, q_pop, count_reg != 2'd0)
    `UTF8D_ASSERT_IMP(a_count_range, 1'b1, count_reg != 2'd3)
    `UTF8D_ASSERT_NXT(a_push_grows, push && !q_pop, count_reg == $past(count_reg) + 2'd1)

endmodule

// ===== src/utf8d_back.sv =====
// Back end: sequence state, character counting and the result register
`include "utf8_stream_decoder_assert.svh"

module utf8d_back
    import utf8d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  q_item_t           q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [CP_W-1:0]   code_point,
    output logic [POS_W-1:0]  start_position,
    output logic [POS_W-1:0]  char_index,
    output logic [POS_W-1:0]  char_count,
    output logic              end_of_string
);

    logic [CP_W-1:0]  partial_reg, partial_next;
    logic [1:0]       rem_reg, rem_next;
    logic [POS_W-1:0] byte_pos_reg, byte_pos_next;
    logic [POS_W-1:0] char_start_reg, char_start_next;
    logic [POS_W-1:0] chars_done_reg, chars_done_next;
    logic             discarding_reg, discarding_next;

    logic             res_valid;
    logic [1:0]       res_status;
    logic [CP_W-1:0]  res_cp;
    logic [POS_W-1:0] res_start, res_idx, res_cnt;
    logic             res_eos;
    logic [CP_W-1:0]  shifted;
    logic [1:0]       rem_dec;

    logic             out_valid_reg;
    logic [1:0]       status_reg;
    logic [CP_W-1:0]  cp_reg;
    logic [POS_W-1:0] start_reg, idx_reg, cnt_reg;
    logic             eos_reg;

    assign q_pop = q_valid && (!out_valid_reg || !out_stall);

    assign shifted = {partial_reg[CP_W-7:0], q_item.data[5:0] & CONT_BITS[5:0]};
    assign rem_dec = rem_reg - 2'd1;

    // One decode step for the byte at the head of the queue
    always_comb
    begin
        partial_next    = partial_reg;
        rem_next        = rem_reg;
        byte_pos_next   = byte_pos_reg;
        char_start_next = char_start_reg;
        chars_done_next = chars_done_reg;
        discarding_next = discarding_reg;
        res_valid       = 1'b0;
        res_status      = STATUS_INVALID;
        res_cp          = '0;
        res_start       = char_start_reg;
        res_idx         = sat_inc(chars_done_reg);
        res_cnt         = chars_done_reg;
        res_eos         = q_item.last;

        if (discarding_reg)
        begin
            if (q_item.last)
            begin
                res_valid  = 1'b1;
                res_status = STATUS_DISCARD;
            end
        end
        else if (rem_reg == 2'd0)
        begin
            char_start_next = byte_pos_reg;
            res_start       = byte_pos_reg;
            case (q_item.cls)
                CLS_ASCII:
                begin
                    chars_done_next = sat_inc(chars_done_reg);
                    res_valid       = 1'b1;
                    res_status      = STATUS_CHAR;
                    res_cp          = {{(CP_W-8){1'b0}}, q_item.data};
                    res_idx         = chars_done_next;
                    res_cnt         = chars_done_next;
                end
                CLS_LEAD2, CLS_LEAD3, CLS_LEAD4:
                begin
                    if (q_item.last)
                    begin
                        partial_next    = '0;
                        res_valid       = 1'b1;
                        discarding_next = 1'b1;
                    end
                    else if (q_item.cls == CLS_LEAD2)
                    begin
                        partial_next = {{(CP_W-8){1'b0}}, q_item.data & LEAD2_BITS};
                        rem_next     = 2'd1;
                    end
                    else if (q_item.cls == CLS_LEAD3)
                    begin
                        partial_next = {{(CP_W-8){1'b0}}, q_item.data & LEAD3_BITS};
                        rem_next     = 2'd2;
                    end
                    else
                    begin
                        partial_next = {{(CP_W-8){1'b0}}, q_item.data & LEAD4_BITS};
                        rem_next     = 2'd3;
                    end
                end
                default:
                begin
                    // stray continuation or an illegal lead byte
                    partial_next    = '0;
                    res_valid       = 1'b1;
                    discarding_next = 1'b1;
                end
            endcase
        end
        else if (q_item.cls == CLS_CONT)
        begin
            rem_next = rem_dec;
            if (rem_dec == 2'd0)
            begin
                chars_done_next = sat_inc(chars_done_reg);
                partial_next    = '0;
                res_valid       = 1'b1;
                res_status      = STATUS_CHAR;
                res_cp          = shifted;
                res_idx         = chars_done_next;
                res_cnt         = chars_done_next;
            end
            else
            begin
                partial_next = shifted;
                // string ends with bytes still missing
                res_valid    = q_item.last;
            end
        end
        else
        begin
            // sequence broken by a non-continuation byte
            partial_next    = '0;
            rem_next        = 2'd0;
            res_valid       = 1'b1;
            discarding_next = 1'b1;
        end

        // End of string returns everything to the reset state
        if (q_item.last)
        begin
            partial_next    = '0;
            rem_next        = 2'd0;
            byte_pos_next   = {{(POS_W-1){1'b0}}, 1'b1};
            char_start_next = {{(POS_W-1){1'b0}}, 1'b1};
            chars_done_next = '0;
            discarding_next = 1'b0;
        end
        else
        begin
            byte_pos_next = sat_inc(byte_pos_reg);
        end
    end

    // Decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg    <= '0;
            rem_reg        <= 2'd0;
            byte_pos_reg   <= {{(POS_W-1){1'b0}}, 1'b1};
            char_start_reg <= {{(POS_W-1){1'b0}}, 1'b1};
            chars_done_reg <= '0;
            discarding_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            partial_reg    <= partial_next;
            rem_reg        <= rem_next;
            byte_pos_reg   <= byte_pos_next;
            char_start_reg <= char_start_next;
            chars_done_reg <= chars_done_next;
            discarding_reg <= discarding_next;
        end
    end

    // Result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (q_pop)
            out_valid_reg <= res_valid;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (q_pop && res_valid)
        begin
            status_reg <= res_status;
            cp_reg     <= res_cp;
            start_reg  <= res_start;
            idx_reg    <= res_idx;
            cnt_reg    <= res_cnt;
            eos_reg    <= res_eos;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign code_point     = cp_reg;
    assign start_position = start_reg;
    assign char_index     = idx_reg;
    assign char_count     = cnt_reg;
    assign end_of_string  = eos_reg;

    `UTF8D_ASSERT_IMP(a_err_no_cp, out_valid_reg && status_reg != STATUS_CHAR, cp_reg == '0)
    `UTF8D_ASSERT_IMP(a_disc_idle, discarding_reg, rem_reg == 2'd0 && partial_reg == '0)
    `UTF8D_ASSERT_IMP(a_disc_only_eos, out_valid_reg && status_reg == STATUS_DISCARD, eos_reg)

endmodule

// ===== src/utf8_stream_decoder.sv =====
// UTF-8 stream decoder, top level
//
// Input channel: one byte of a string per transfer on data_byte, with
// last_byte set on the string's final byte; in_valid / in_stall handshake.
// Output channel: at most one result per byte (status, code_point,
// start_position, char_index, char_count, end_of_string) with out_valid /
// out_stall. Bytes that only extend a sequence, and bytes dropped after an
// error, give no result; the last byte of a string after an error gives
// status 2.
// A byte's transfer writes it into the front queue; the decode step then
// moves it from the queue into the result register, where any result it
// gives is presented.
// Throughput: one byte per cycle unless out_stall holds a presented result,
// set by the decode step in the back end; a two-entry queue lets the front
// keep taking bytes while the result register is held.
// Reset clears the queue, the result valid flag and all sequence state, so the
// next byte starts a new string at position 1.
// While out_stall is high a presented result holds; the back end stops, the queue
// fills, and in_stall rises once both entries are occupied.
module utf8_stream_decoder
    import utf8d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic              in_valid,
    output logic              in_stall,
    output logic [1:0]        status,
    output logic [CP_W-1:0]   code_point,
    output logic [POS_W-1:0]  start_position,
    output logic [POS_W-1:0]  char_index,
    output logic [POS_W-1:0]  char_count,
    output logic              end_of_string,
    output logic              out_valid,
    input  logic              out_stall
);

    logic    q_valid;
    logic    q_pop;
    q_item_t q_item;

    // Classification and queue
    utf8d_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    // Sequence decode and result register
    utf8d_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .code_point     (code_point),
        .start_position (start_position),
        .char_index     (char_index),
        .char_count     (char_count),
        .end_of_string  (end_of_string)
    );

endmodule

// ===== tb/sv/utf8_decode_checker.sv =====
`timescale 1ns / 100ps
// Checker for the UTF-8 stream decoder: watches both channels, predicts results, compares them
module utf8_decode_checker
    import utf8d_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic [1:0]       status,
    input  logic [CP_W-1:0]  code_point,
    input  logic [POS_W-1:0] start_position,
    input  logic [POS_W-1:0] char_index,
    input  logic [POS_W-1:0] char_count,
    input  logic             end_of_string,
    input  logic             out_valid,
    input  logic             out_stall,
    output int               fail_count,
    output int               pending_results,
    output int               chars_seen,
    output int               invalid_seen,
    output int               discard_seen
);

    // Past this many, mismatches are only counted
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [1:0]       status;
        logic [CP_W-1:0]  code_point;
        logic [POS_W-1:0] start_position;
        logic [POS_W-1:0] char_index;
        logic [POS_W-1:0] char_count;
        logic             end_of_string;
    } char_result_t;

    // Results predicted but not yet seen on the output
    char_result_t     decode_q[$];

    // Decoder state as predicted
    logic [CP_W-1:0]  acc;
    logic [1:0]       left;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] seq_start;
    logic [POS_W-1:0] done;
    logic             dropping;

    int errs;
    int n_chars;
    int n_invalid;
    int n_discard;

    // Position and count increment, holding at the limit
    function automatic logic [POS_W-1:0] bump(input logic [POS_W-1:0] v);
        return (v == MAX_BYTES) ? v : v + 17'd1;
    endfunction

    // Back to the start of a new string
    task automatic clear_string();
        acc       = '0;
        left      = '0;
        pos       = 17'd1;
        seq_start = 17'd1;
        done      = '0;
        dropping  = 1'b0;
    endtask

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            if (errs < MAX_REPORTS)
                $error("%s: expected %0d, actual %0d", fname, want, got);
            errs++;
        end
    endtask

    // Advance the decoder by one byte; queue the result it gives, if any
    task automatic decode_step(input logic [7:0] b, input logic lst);
        char_result_t r;
        logic [1:0]   need;
        logic         give;
        logic         bad;
        give = 1'b0;
        bad  = 1'b0;
        r    = '0;
        r.end_of_string = lst;
        if (dropping)
        begin
            // only the string's last byte ends the drop, and it says so
            if (lst)
            begin
                give     = 1'b1;
                r.status = STATUS_DISCARD;
            end
        end
        else if (left == 2'd0)
        begin
            seq_start = pos;
            if ((b & TOP1_MASK) == 8'd0)
            begin
                done         = bump(done);
                give         = 1'b1;
                r.status     = STATUS_CHAR;
                r.code_point = CP_W'(b);
            end
            else
            begin
                need = 2'd0;
                if ((b & TOP3_MASK) == LEAD2_FORM)
                begin
                    acc  = CP_W'(b & LEAD2_BITS);
                    need = 2'd1;
                end
                else if ((b & TOP4_MASK) == LEAD3_FORM)
                begin
                    acc  = CP_W'(b & LEAD3_BITS);
                    need = 2'd2;
                end
                else if ((b & TOP5_MASK) == LEAD4_FORM)
                begin
                    acc  = CP_W'(b & LEAD4_BITS);
                    need = 2'd3;
                end
                // stray continuation, 0xF8 and up, or a lead on the last byte
                if (need == 2'd0 || lst)
                    bad = 1'b1;
                else
                    left = need;
            end
        end
        else if ((b & TOP2_MASK) == CONT_FORM)
        begin
            acc  = {acc[CP_W-7:0], b[5:0]};
            left = left - 2'd1;
            if (left == 2'd0)
            begin
                done         = bump(done);
                give         = 1'b1;
                r.status     = STATUS_CHAR;
                r.code_point = acc;
                acc          = '0;
            end
            else if (lst)
            begin
                // string ends with continuation bytes still owed
                give     = 1'b1;
                r.status = STATUS_INVALID;
            end
        end
        else
        begin
            // non-continuation inside a sequence: dropped, not taken as a lead
            bad  = 1'b1;
            left = '0;
        end

        if (bad)
        begin
            acc      = '0;
            dropping = 1'b1;
            give     = 1'b1;
            r.status = STATUS_INVALID;
        end

        r.start_position = seq_start;
        if (r.status == STATUS_CHAR)
        begin
            r.char_index = done;
            r.char_count = done;
        end
        else
        begin
            r.char_index = bump(done);
            r.char_count = done;
        end
        if (give)
            decode_q.insert(decode_q.size(), r);

        if (lst)
            clear_string();
        else
            pos = bump(pos);
    endtask

    // Results first: none can stem from a byte taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        char_result_t want;
        if (!rst_n)
        begin
            decode_q.delete();
            clear_string();
            errs      = 0;
            n_chars   = 0;
            n_invalid = 0;
            n_discard = 0;
            fail_count      <= 0;
            pending_results <= 0;
            chars_seen      <= 0;
            invalid_seen    <= 0;
            discard_seen    <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (decode_q.size() == 0)
                begin
                    if (errs < MAX_REPORTS)
                        $error("result transfer with nothing pending: status %0d", status);
                    errs++;
                end
                else
                begin
                    want = decode_q.pop_front();
                    check_field("status", want.status, status);
                    check_field("code_point", want.code_point, code_point);
                    check_field("start_position", want.start_position, start_position);
                    check_field("char_index", want.char_index, char_index);
                    check_field("char_count", want.char_count, char_count);
                    check_field("end_of_string", want.end_of_string, end_of_string);
                    case (want.status)
                        STATUS_CHAR:    n_chars++;
                        STATUS_INVALID: n_invalid++;
                        default:        n_discard++;
                    endcase
                end
            end
            if (in_valid && !in_stall)
                decode_step(data_byte, last_byte);

            fail_count      <= errs;
            pending_results <= decode_q.size();
            chars_seen      <= n_chars;
            invalid_seen    <= n_invalid;
            discard_seen    <= n_discard;
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the UTF-8 stream decoder testbench: clock, reset, byte stimulus and verdict
module testbench;
    import utf8d_pkg::*;

    localparam int     RANDOM_BYTES = 1850;
    localparam int     HOLD_CYCLES  = 60;
    localparam int     SETTLE       = 6;
    localparam longint TIMEOUT_NS   = 8_000_000;

    logic             clk = 1'b0;
    logic             rst_n;
    logic [7:0]       data_byte;
    logic             last_byte;
    logic             in_valid;
    logic             in_stall;
    logic [1:0]       status;
    logic [CP_W-1:0]  code_point;
    logic [POS_W-1:0] start_position;
    logic [POS_W-1:0] char_index;
    logic [POS_W-1:0] char_count;
    logic             end_of_string;
    logic             out_valid;
    logic             out_stall;

    int fail_count;
    int pending_results;
    int chars_seen;
    int invalid_seen;
    int discard_seen;

    // Idling control shared between the sender and the receiver
    bit sender_calm   = 1'b0;
    bit receiver_calm = 1'b0;
    int holds_asked   = 0;

    logic [7:0] str_q[$];
    int         bytes_sent   = 0;
    int         strings_sent = 0;

    utf8_stream_decoder u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .status         (status),
        .code_point     (code_point),
        .start_position (start_position),
        .char_index     (char_index),
        .char_count     (char_count),
        .end_of_string  (end_of_string),
        .out_valid      (out_valid),
        .out_stall      (out_stall)
    );

    utf8_decode_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .data_byte       (data_byte),
        .last_byte       (last_byte),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .status          (status),
        .code_point      (code_point),
        .start_position  (start_position),
        .char_index      (char_index),
        .char_count      (char_count),
        .end_of_string   (end_of_string),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .chars_seen      (chars_seen),
        .invalid_seen    (invalid_seen),
        .discard_seen    (discard_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One byte transfer; returns at the edge that takes it
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= lst;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
    endtask

    // Send the built string, flagging its final byte
    task automatic send_string();
        for (int i = 0; i < str_q.size(); i++)
            send_byte(str_q[i], i == str_q.size() - 1);
        strings_sent++;
        str_q.delete();
    endtask

    // Pause the sender until every predicted result has come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Add one byte to the end of the string being built
    task automatic append_byte(input logic [7:0] b);
        str_q = {str_q, b};
    endtask

    function automatic logic [7:0] cont_byte();
        return CONT_FORM | (8'($urandom) & CONT_BITS);
    endfunction

    // Lead byte of a character with n continuation bytes, payload bits random
    function automatic logic [7:0] lead_byte(input int n);
        case (n)
            0:       return 8'($urandom_range(0, 127));
            1:       return LEAD2_FORM | (8'($urandom) & LEAD2_BITS);
            2:       return LEAD3_FORM | (8'($urandom) & LEAD3_BITS);
            default: return LEAD4_FORM | (8'($urandom) & LEAD4_BITS);
        endcase
    endfunction

    task automatic add_char(input int n);
        append_byte(lead_byte(n));
        repeat (n) append_byte(cont_byte());
    endtask

    // Append one malformed piece; ends_here set when the string must stop on it
    task automatic add_fault(output bit ends_here);
        int         kind;
        int         len;
        logic [7:0] b;
        ends_here = 1'b0;
        kind = $urandom_range(0, 3);
        case (kind)
            0: append_byte(cont_byte());
            1: append_byte(TOP5_MASK | 8'($urandom_range(0, 7)));
            2:
            begin
                // sequence broken by a byte that is not a continuation
                len = $urandom_range(1, 3);
                append_byte(lead_byte(len));
                repeat ($urandom_range(0, len - 1)) append_byte(cont_byte());
                do
                    b = 8'($urandom);
                while ((b & TOP2_MASK) == CONT_FORM);
                append_byte(b);
            end
            default:
            begin
                // string cut off inside a sequence
                len = $urandom_range(1, 3);
                append_byte(lead_byte(len));
                repeat ($urandom_range(0, len - 1)) append_byte(cont_byte());
                ends_here = 1'b1;
            end
        endcase
    endtask

    // Receiver: a fresh stall draw after each result transfer, plus one long hold-off
    initial
    begin
        int wait_n;
        int holds_done;
        holds_done = 0;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (holds_done < holds_asked)
            begin
                holds_done++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (out_valid && !out_stall)
            begin
                wait_n = receiver_calm ? 0 : $urandom_range(0, 17);
                if (wait_n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (wait_n) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int nchars;
        bit faulted;
        bit ends;
        rst_n = 1'b0;
        in_valid  <= 1'b0;
        data_byte <= '0;
        last_byte <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes and each malformed case
        str_q = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                  8'hF7, 8'hBF, 8'hBF, 8'hBF};
        send_string();
        str_q = '{8'h80, 8'h41, 8'h42};     // stray continuation, then drop
        send_string();
        str_q = '{8'hFF};                   // invalid lead on the last byte
        send_string();
        str_q = '{8'hE2, 8'h41, 8'h5A};     // broken sequence, then drop
        send_string();
        str_q = '{8'hF0, 8'h90, 8'h80};     // ends one continuation short
        send_string();
        str_q = '{8'hC3};                   // multi-byte lead as last byte
        send_string();
        str_q = '{8'h41};
        send_string();
        wait_idle();

        // Long receiver hold-off while bytes keep coming
        sender_calm = 1'b1;
        holds_asked++;
        repeat (24) add_char($urandom_range(0, 3));
        send_string();
        wait_idle();

        // Random strings: mostly well formed, some with one fault, some of random bytes
        while (bytes_sent < RANDOM_BYTES)
        begin
            sender_calm   = ($urandom_range(0, 3) == 0);
            receiver_calm = ($urandom_range(0, 3) == 0);
            faulted = 1'b0;
            ends    = 1'b0;
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 8)) append_byte(8'($urandom));
            end
            else
            begin
                nchars = $urandom_range(1, 12);
                for (int k = 0; k < nchars && !ends; k++)
                begin
                    if (!faulted && $urandom_range(0, 19) == 0)
                    begin
                        add_fault(ends);
                        faulted = 1'b1;
                    end
                    else
                        add_char($urandom_range(0, 3));
                end
            end
            send_string();
            if ($urandom_range(0, 24) == 0)
                wait_idle();
        end
        wait_idle();

        $display("Covered %0d bytes in %0d strings, with idle gaps, stalls and one long hold-off.",
                 bytes_sent, strings_sent);
        $display("Checked %0d characters, %0d invalid sequences, %0d dropped string ends.",
                 chars_seen, invalid_seen, discard_seen);
        if (fail_count == 0)
            $display("** utf8_stream_decoder: PASSED **");
        else
            $display("** utf8_stream_decoder: FAILED **");
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d results outstanding.", pending_results);
        $display("** utf8_stream_decoder: FAILED **");
        $finish;
    end

endmodule
